// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds outside of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== design/pee_pkg.sv =====
package pee_pkg;

    // Pipeline section depths
    localparam int LOG_STEPS = 32;
    localparam int DIV_STEPS = 9;
    localparam int DIV_BITS  = 6;
    localparam int IMP_STEPS = 17;

    // ln(2) in Q32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Common denominator is 3125 * 2^51; half of it for rounding
    localparam logic [12:0]  DIV_CONST  = 13'd3125;
    localparam logic [103:0] ROUND_HALF = 104'd3125 << 50;

    // Exergy saturation bounds
    localparam logic [39:0] EX_POS_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] EX_NEG_MAG = 40'h80_0000_0000;

    localparam logic [23:0] DESTR_MAX = 24'hFF_FFFF;
    localparam logic [16:0] IMP_ONE   = 17'd65536;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DENSITY = 2'd0,
        CFG_HEAT    = 2'd1,
        CFG_DREF    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] flow_rate;
        logic [15:0] pump_head;
        logic [23:0] electrical_power;
        logic [16:0] fluid_temperature;
        logic [16:0] ambient_temperature;
        logic [23:0] fluid_pressure;
        logic [23:0] ambient_pressure;
    } t_in_req;

    typedef struct packed {
        logic [23:0] energy_rate;
        logic [39:0] exergy_rate;
        logic [23:0] exergy_destruction;
        logic [16:0] impact_factor;
    } t_out_res;

    // Logarithm iteration state: exponent, Q31 mantissa, fraction bits so far
    typedef struct packed {
        logic [4:0]  e;
        logic [31:0] m;
        logic [31:0] frac;
    } t_log;

    // Terms carried alongside the logarithm section
    typedef struct packed {
        logic [23:0] pel;
        logic [16:0] t;
        logic [16:0] t0;
        logic [48:0] k;
        logic [56:0] b;
        logic [48:0] c;
        logic        cneg;
    } t_side;

    // Terms carried past the thermal product
    typedef struct packed {
        logic [23:0] pel;
        logic [56:0] b;
        logic [48:0] c;
        logic        cneg;
    } t_late;

    // One radix-64 step of the division by 3125
    typedef struct packed {
        logic [11:0] rem;
        logic [5:0]  q;
    } t_dstep;

endpackage

// ===== design/pump_exergy_evaluator_top.sv =====
// Channel   | valid       | stall       | payload
// ----------+-------------+-------------+-----------------------
// input     | i_in_valid  | o_in_stall  | i_in_req  (t_in_req)
// output    | o_out_valid | i_out_stall | o_out_res (t_out_res)
// config    | i_cfg_we    | (none)      | i_cfg_index, i_cfg_data
//
// One request enters per cycle while o_in_stall is low; results leave in request order.
// The depth is set by the 32 squaring stages of the logarithm, the 9 stages of
// the division by 3125 and the 17 stages of the impact-factor divider.
// Reset is synchronous, active low; it clears the valid bits and loads the config defaults.
// A stalled output holds; the pipeline keeps moving into its empty last stage.
module pump_exergy_evaluator_top import pee_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_res    o_out_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

`include "assert_macros.svh"

    // ---------------------------------------------------------------
    // Helper functions
    // ---------------------------------------------------------------

    // Normalize a temperature to a Q31 mantissa and its exponent
    function automatic t_log f_ln_init(input logic [16:0] x);
        logic [4:0]  e;
        logic [31:0] xw;
        t_log        res;
        e = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (x[i]) begin
                e = 5'(i);
            end
        end
        xw = {15'd0, x};
        res.e = e;
        res.m = xw << (5'd31 - e);
        res.frac = 32'd0;
        return res;
    endfunction

    // Square the mantissa and take one fraction bit of log2
    function automatic t_log f_ln_step(input t_log x);
        logic [63:0] sq;
        t_log        res;
        sq = {32'd0, x.m} * {32'd0, x.m};
        res = x;
        if (sq[63]) begin
            res.m = sq[63:32];
            res.frac = {x.frac[30:0], 1'b1};
        end else begin
            res.m = sq[62:31];
            res.frac = {x.frac[30:0], 1'b0};
        end
        return res;
    endfunction

    // Scale exponent and fraction by ln(2), round the fraction part
    function automatic logic [36:0] f_ln_fin(input t_log x);
        logic [36:0] ep;
        logic [64:0] fp;
        ep = {32'd0, x.e} * {5'd0, LN2_Q32};
        fp = {33'd0, x.frac} * {33'd0, LN2_Q32} + 65'h0_8000_0000;
        return ep + {5'd0, fp[63:32]};
    endfunction

    // Six restoring steps of the division by 3125
    function automatic t_dstep f_div6(input logic [11:0] rem, input logic [5:0] bits);
        logic [12:0] acc;
        t_dstep      res;
        res.rem = rem;
        res.q = 6'd0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            acc = {res.rem, bits[i]};
            if (acc >= DIV_CONST) begin
                acc = acc - DIV_CONST;
                res.q[i] = 1'b1;
            end
            res.rem = acc[11:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [10:0] r_cfg_density;
    logic [12:0] r_cfg_heat;
    logic [23:0] r_cfg_dref;
    logic [23:0] w_refe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_density <= 11'd1000;
            r_cfg_heat    <= 13'd4182;
            r_cfg_dref    <= 24'd2560;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DENSITY: r_cfg_density <= i_cfg_data[10:0];
                CFG_HEAT:    r_cfg_heat    <= i_cfg_data[12:0];
                CFG_DREF:    r_cfg_dref    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero reference acts as one
    assign w_refe = (r_cfg_dref == 24'd0) ? 24'd1 : r_cfg_dref;

    // ---------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------
    logic                w_adv;

    logic                r_s1_vld;
    t_in_req             r_s1_req;
    logic [23:0]         r_s1_cprho;
    logic [20:0]         r_s1_rho981;
    logic [28:0]         r_s1_dp25;
    logic                r_s1_cneg;

    logic                r_s2_vld;
    logic [43:0]         r_s2_k0;
    logic [40:0]         r_s2_b0;
    logic [48:0]         r_s2_c;
    logic                r_s2_cneg;
    logic [15:0]         r_s2_head;
    logic [23:0]         r_s2_pel;
    logic [16:0]         r_s2_t;
    logic [16:0]         r_s2_t0;

    logic [LOG_STEPS:0]  r_lg_vld;
    t_side               r_lg_side [0:LOG_STEPS];
    t_log                r_lg_a    [0:LOG_STEPS];
    t_log                r_lg_b    [0:LOG_STEPS];

    logic [8:0]          r_e_vld;
    t_side               r_e1_side;
    logic [36:0]         r_e1_ln_a;
    logic [36:0]         r_e1_ln_b;
    t_side               r_e2_side;
    logic signed [37:0]  r_e2_lr;
    logic signed [17:0]  r_e2_dt;
    t_side               r_e3_side;
    logic signed [55:0]  r_e3_prod;
    logic signed [17:0]  r_e3_dt;
    t_side               r_e4_side;
    logic [53:0]         r_e4_dq;
    t_late               r_e5_late;
    logic [51:0]         r_e5_pp0;
    logic [51:0]         r_e5_pp1;
    logic [50:0]         r_e5_pp2;
    logic [50:0]         r_e5_pp3;
    t_late               r_e6_late;
    logic [79:0]         r_e6_lo;
    logic [78:0]         r_e6_hi;
    logic [23:0]         r_e7_pel;
    logic [103:0]        r_e7_a;
    logic [103:0]        r_e7_bc;
    logic [23:0]         r_e8_pel;
    logic [103:0]        r_e8_s;
    logic [23:0]         r_e9_pel;
    logic                r_e9_neg;
    logic [102:0]        r_e9_mag;

    logic [DIV_STEPS:0]  r_dv_vld;
    logic [53:0]         r_dv_num [0:DIV_STEPS];
    logic [11:0]         r_dv_rem [0:DIV_STEPS];
    logic [53:0]         r_dv_quo [0:DIV_STEPS];
    logic                r_dv_neg [0:DIV_STEPS];
    logic [23:0]         r_dv_pel [0:DIV_STEPS];

    logic [1:0]          r_x_vld;
    logic [23:0]         r_e11_pel;
    logic [39:0]         r_e11_ex;
    logic [23:0]         r_e12_pel;
    logic [39:0]         r_e12_ex;
    logic [23:0]         r_e12_destr;

    logic [IMP_STEPS:0]  r_im_vld;
    logic [40:0]         r_im_rem   [0:IMP_STEPS];
    logic [16:0]         r_im_quo   [0:IMP_STEPS];
    logic                r_im_ovf   [0:IMP_STEPS];
    logic [23:0]         r_im_destr [0:IMP_STEPS];
    logic [39:0]         r_im_ex    [0:IMP_STEPS];
    logic [23:0]         r_im_pel   [0:IMP_STEPS];

    logic                r_out_vld;
    t_out_res            r_out_res;
    logic                w_out_load;

    // Advance unless a valid last stage faces a held output
    assign w_adv      = !(r_im_vld[IMP_STEPS] && r_out_vld && i_out_stall);
    assign w_out_load = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    // ---------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_lg_vld <= '0;
            r_e_vld  <= '0;
            r_dv_vld <= '0;
            r_x_vld  <= '0;
            r_im_vld <= '0;
        end else if (w_adv) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_lg_vld <= {r_lg_vld[LOG_STEPS-1:0], r_s2_vld};
            r_e_vld  <= {r_e_vld[7:0], r_lg_vld[LOG_STEPS]};
            r_dv_vld <= {r_dv_vld[DIV_STEPS-1:0], r_e_vld[8]};
            r_x_vld  <= {r_x_vld[0], r_dv_vld[DIV_STEPS]};
            r_im_vld <= {r_im_vld[IMP_STEPS-1:0], r_x_vld[1]};
        end
    end

    // ---------------------------------------------------------------
    // Front: coefficient products and pressure difference
    // ---------------------------------------------------------------
    logic [23:0] w_s1_dp;

    assign w_s1_dp = (i_in_req.fluid_pressure >= i_in_req.ambient_pressure)
                   ? (i_in_req.fluid_pressure - i_in_req.ambient_pressure)
                   : (i_in_req.ambient_pressure - i_in_req.fluid_pressure);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_req    <= i_in_req;
            r_s1_cprho  <= {11'd0, r_cfg_heat} * {13'd0, r_cfg_density};
            r_s1_rho981 <= {10'd0, r_cfg_density} * 21'd981;
            r_s1_dp25   <= ({5'd0, w_s1_dp} << 4) + ({5'd0, w_s1_dp} << 3) + {5'd0, w_s1_dp};
            r_s1_cneg   <= (i_in_req.fluid_pressure < i_in_req.ambient_pressure);
        end
    end

    // Multiply by flow
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_k0   <= {20'd0, r_s1_cprho} * {24'd0, r_s1_req.flow_rate};
            r_s2_b0   <= {20'd0, r_s1_rho981} * {21'd0, r_s1_req.flow_rate};
            r_s2_c    <= {20'd0, r_s1_dp25} * {29'd0, r_s1_req.flow_rate};
            r_s2_cneg <= r_s1_cneg;
            r_s2_head <= r_s1_req.pump_head;
            r_s2_pel  <= r_s1_req.electrical_power;
            r_s2_t    <= r_s1_req.fluid_temperature;
            r_s2_t0   <= r_s1_req.ambient_temperature;
        end
    end

    // ---------------------------------------------------------------
    // Logarithm section: normalize, then one squaring per stage
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lg_side[0].pel  <= r_s2_pel;
            r_lg_side[0].t    <= r_s2_t;
            r_lg_side[0].t0   <= r_s2_t0;
            r_lg_side[0].k    <= ({5'd0, r_s2_k0} << 4) + ({5'd0, r_s2_k0} << 3)
                               + {5'd0, r_s2_k0};
            r_lg_side[0].b    <= {16'd0, r_s2_b0} * {41'd0, r_s2_head};
            r_lg_side[0].c    <= r_s2_c;
            r_lg_side[0].cneg <= r_s2_cneg;
            r_lg_a[0]         <= f_ln_init(r_s2_t);
            r_lg_b[0]         <= f_ln_init(r_s2_t0);
            for (int k = 1; k <= LOG_STEPS; k++) begin
                r_lg_side[k] <= r_lg_side[k-1];
                r_lg_a[k]    <= f_ln_step(r_lg_a[k-1]);
                r_lg_b[k]    <= f_ln_step(r_lg_b[k-1]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Thermal difference D in units of 2^-40 K
    // ---------------------------------------------------------------
    logic signed [57:0] w_e4_dfull;
    logic               w_e4_zero;

    assign w_e4_dfull = $signed({{8{r_e3_dt[17]}}, r_e3_dt, 32'd0})
                      - $signed({{2{r_e3_prod[55]}}, r_e3_prod});
    assign w_e4_zero  = (r_e3_side.t == 17'd0) || (r_e3_side.t0 == 17'd0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // finish both logarithms
            r_e1_side <= r_lg_side[LOG_STEPS];
            r_e1_ln_a <= f_ln_fin(r_lg_a[LOG_STEPS]);
            r_e1_ln_b <= f_ln_fin(r_lg_b[LOG_STEPS]);
            // log ratio and temperature difference
            r_e2_side <= r_e1_side;
            r_e2_lr   <= $signed({1'b0, r_e1_ln_a}) - $signed({1'b0, r_e1_ln_b});
            r_e2_dt   <= $signed({1'b0, r_e1_side.t}) - $signed({1'b0, r_e1_side.t0});
            // T0 times log ratio
            r_e3_side <= r_e2_side;
            r_e3_prod <= $signed({1'b0, r_e2_side.t0}) * r_e2_lr;
            r_e3_dt   <= r_e2_dt;
            // drop negative D and zero temperatures
            r_e4_side <= r_e3_side;
            r_e4_dq   <= (w_e4_zero || w_e4_dfull[57]) ? 54'd0 : w_e4_dfull[53:0];
        end
    end

    // ---------------------------------------------------------------
    // Sum of the three terms over the common denominator
    // ---------------------------------------------------------------
    logic [103:0] w_e9_mag;
    logic [103:0] w_dv_sum;

    assign w_e9_mag = r_e8_s[103] ? (~r_e8_s + 104'd1) : r_e8_s;
    assign w_dv_sum = {1'b0, r_e9_mag} + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // partial products of the thermal term
            r_e5_late.pel  <= r_e4_side.pel;
            r_e5_late.b    <= r_e4_side.b;
            r_e5_late.c    <= r_e4_side.c;
            r_e5_late.cneg <= r_e4_side.cneg;
            r_e5_pp0 <= {27'd0, r_e4_side.k[24:0]} * {25'd0, r_e4_dq[26:0]};
            r_e5_pp1 <= {27'd0, r_e4_side.k[24:0]} * {25'd0, r_e4_dq[53:27]};
            r_e5_pp2 <= {27'd0, r_e4_side.k[48:25]} * {24'd0, r_e4_dq[26:0]};
            r_e5_pp3 <= {27'd0, r_e4_side.k[48:25]} * {24'd0, r_e4_dq[53:27]};
            // pair up partial products
            r_e6_late <= r_e5_late;
            r_e6_lo   <= {28'd0, r_e5_pp0} + {1'b0, r_e5_pp1, 27'd0};
            r_e6_hi   <= {28'd0, r_e5_pp2} + {1'b0, r_e5_pp3, 27'd0};
            // thermal term, hydraulic plus pressure term
            r_e7_pel <= r_e6_late.pel;
            r_e7_a   <= {24'd0, r_e6_lo} + {r_e6_hi, 25'd0};
            r_e7_bc  <= r_e6_late.cneg
                      ? ({17'd0, r_e6_late.b, 30'd0} - {15'd0, r_e6_late.c, 40'd0})
                      : ({17'd0, r_e6_late.b, 30'd0} + {15'd0, r_e6_late.c, 40'd0});
            // signed total
            r_e8_pel <= r_e7_pel;
            r_e8_s   <= r_e7_a + r_e7_bc;
            // sign and magnitude
            r_e9_pel <= r_e8_pel;
            r_e9_neg <= r_e8_s[103];
            r_e9_mag <= w_e9_mag[102:0];
        end
    end

    // ---------------------------------------------------------------
    // Division by 3125 after the shift by 51, six bits per stage
    // ---------------------------------------------------------------
    t_dstep w_dv_step [1:DIV_STEPS];

    always_comb begin
        for (int k = 1; k <= DIV_STEPS; k++) begin
            w_dv_step[k] = f_div6(r_dv_rem[k-1], r_dv_num[k-1][53:48]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_num[0] <= {1'b0, w_dv_sum[103:51]};
            r_dv_rem[0] <= 12'd0;
            r_dv_quo[0] <= 54'd0;
            r_dv_neg[0] <= r_e9_neg;
            r_dv_pel[0] <= r_e9_pel;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv_num[k] <= r_dv_num[k-1] << DIV_BITS;
                r_dv_rem[k] <= w_dv_step[k].rem;
                r_dv_quo[k] <= {r_dv_quo[k-1][47:0], w_dv_step[k].q};
                r_dv_neg[k] <= r_dv_neg[k-1];
                r_dv_pel[k] <= r_dv_pel[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Saturate exergy and form destruction
    // ---------------------------------------------------------------
    logic [39:0] w_e11_lim;
    logic [39:0] w_e11_mag;
    logic [41:0] w_e12_diff;
    logic [23:0] w_e12_destr;

    assign w_e11_lim = r_dv_neg[DIV_STEPS] ? EX_NEG_MAG : EX_POS_MAX;
    assign w_e11_mag = (r_dv_quo[DIV_STEPS] > {14'd0, w_e11_lim})
                     ? w_e11_lim : r_dv_quo[DIV_STEPS][39:0];

    assign w_e12_diff = {18'd0, r_e11_pel} - {{2{r_e11_ex[39]}}, r_e11_ex};

    always_comb begin
        if (w_e12_diff[41] || (w_e12_diff == 42'd0)) begin
            w_e12_destr = 24'd0;
        end else if (|w_e12_diff[40:24]) begin
            w_e12_destr = DESTR_MAX;
        end else begin
            w_e12_destr = w_e12_diff[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e11_pel   <= r_dv_pel[DIV_STEPS];
            r_e11_ex    <= r_dv_neg[DIV_STEPS] ? (~w_e11_mag + 40'd1) : w_e11_mag;
            r_e12_pel   <= r_e11_pel;
            r_e12_ex    <= r_e11_ex;
            r_e12_destr <= w_e12_destr;
        end
    end

    // ---------------------------------------------------------------
    // Impact factor: restoring divider, one quotient bit per stage
    // ---------------------------------------------------------------
    logic [40:0] w_im_num;
    logic [40:0] w_im_dsr [1:IMP_STEPS];
    logic        w_im_ge  [1:IMP_STEPS];

    assign w_im_num = {1'b0, r_e12_destr, 16'd0} + {18'd0, w_refe[23:1]};

    always_comb begin
        for (int k = 1; k <= IMP_STEPS; k++) begin
            w_im_dsr[k] = {17'd0, w_refe} << (IMP_STEPS - k);
            w_im_ge[k]  = (r_im_rem[k-1] >= w_im_dsr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_im_rem[0]   <= w_im_num;
            r_im_quo[0]   <= 17'd0;
            r_im_ovf[0]   <= (w_im_num >= {w_refe, 17'd0});
            r_im_destr[0] <= r_e12_destr;
            r_im_ex[0]    <= r_e12_ex;
            r_im_pel[0]   <= r_e12_pel;
            for (int k = 1; k <= IMP_STEPS; k++) begin
                r_im_rem[k]   <= w_im_ge[k] ? (r_im_rem[k-1] - w_im_dsr[k]) : r_im_rem[k-1];
                r_im_quo[k]   <= {r_im_quo[k-1][15:0], w_im_ge[k]};
                r_im_ovf[k]   <= r_im_ovf[k-1];
                r_im_destr[k] <= r_im_destr[k-1];
                r_im_ex[k]    <= r_im_ex[k-1];
                r_im_pel[k]   <= r_im_pel[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold while stalled
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= r_im_vld[IMP_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_res.energy_rate        <= r_im_pel[IMP_STEPS];
            r_out_res.exergy_rate        <= r_im_ex[IMP_STEPS];
            r_out_res.exergy_destruction <= r_im_destr[IMP_STEPS];
            r_out_res.impact_factor      <= (r_im_ovf[IMP_STEPS]
                                            || (r_im_quo[IMP_STEPS] > IMP_ONE))
                                          ? IMP_ONE : r_im_quo[IMP_STEPS];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out_res;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic w_chk_covered;

    assign w_chk_covered = ($signed(o_out_res.exergy_rate)
                            >= $signed({16'd0, o_out_res.energy_rate}));

    `ASSERT_CLK(a_destr_floor, (o_out_valid && w_chk_covered) |-> (o_out_res.exergy_destruction == 24'd0), "destruction not zero while exergy covers input power")
    `ASSERT_CLK(a_impact_clamp, o_out_valid |-> (o_out_res.impact_factor <= IMP_ONE), "impact factor above one")
    `ASSERT_CLK(a_no_drop, (r_im_vld[IMP_STEPS] && r_out_vld && i_out_stall) |=> r_im_vld[IMP_STEPS], "last stage lost a request while output held")
    `ASSERT_CLK(a_stall_full, o_in_stall |-> (r_out_vld && r_im_vld[IMP_STEPS]), "input stalled with room in the pipeline")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import pee_pkg::*;

    localparam logic [1:0]   CFG_UNUSED = 2'd3;
    localparam logic [127:0] EXERGY_DEN = 128'd3125 << 51;
    localparam int           DRAIN_CYCLES = 100;
    localparam int           MAX_REPORTS = 10;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in_req;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_res    o_out_res;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    // shadow copy of the configuration registers
    logic [10:0] density_q;
    logic [12:0] heat_cap_q;
    logic [23:0] dref_q;

    t_out_res result_q[$];
    t_row     rows[$];
    int       mismatches;
    int       requests_sent;
    int       results_seen;
    bit       quiet;

    pump_exergy_evaluator_top DUT (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ln(x) in Q32 from integer log2 plus 32 bits by repeated squaring
    function automatic logic [63:0] ln_q32(input logic [16:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        while (e < 16 && (x >> (e + 1)) != 0) e++;
        m = 64'(x) << (31 - e);
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return 64'(e) * LN2_Q32 + ((frac * LN2_Q32 + 64'h8000_0000) >> 32);
    endfunction

    // energy, exergy, destruction and impact for one telemetry sample
    function automatic t_out_res exergy_eval(input t_in_req r);
        logic signed [63:0] dq;
        logic signed [63:0] lr;
        logic signed [63:0] st;
        logic signed [63:0] st0;
        logic signed [63:0] ex;
        logic signed [63:0] diff;
        logic [63:0]        k;
        logic [127:0]       pos;
        logic [127:0]       neg;
        logic [127:0]       mag;
        logic [127:0]       q;
        logic [127:0]       lim;
        logic [63:0]        destr;
        logic [63:0]        refv;
        logic [63:0]        imp;
        bit                 negative;
        t_out_res           o;
        dq = 0;
        if (r.fluid_temperature != 0 && r.ambient_temperature != 0) begin
            st = 64'(r.fluid_temperature);
            st0 = 64'(r.ambient_temperature);
            lr = $signed(ln_q32(r.fluid_temperature)) - $signed(ln_q32(r.ambient_temperature));
            dq = (st - st0) * 64'sd4294967296 - st0 * lr;
            if (dq < 0) dq = 0;
        end
        k = 64'(heat_cap_q) * density_q * r.flow_rate * 25;
        pos = 128'(k) * {64'd0, dq};
        k = 64'(density_q) * 981 * r.flow_rate;
        pos = pos + ((128'(k) * r.pump_head) << 30);
        neg = '0;
        if (r.fluid_pressure >= r.ambient_pressure) begin
            k = (64'(r.fluid_pressure) - r.ambient_pressure) * 25;
            pos = pos + ((128'(k) * r.flow_rate) << 40);
        end else begin
            k = (64'(r.ambient_pressure) - r.fluid_pressure) * 25;
            neg = (128'(k) * r.flow_rate) << 40;
        end
        negative = pos < neg;
        mag = negative ? neg - pos : pos - neg;
        q = (mag + EXERGY_DEN / 2) / EXERGY_DEN;
        lim = negative ? 128'(EX_NEG_MAG) : 128'(EX_POS_MAX);
        if (q > lim) q = lim;
        ex = negative ? -$signed(q[63:0]) : $signed(q[63:0]);
        diff = $signed(64'(r.electrical_power)) - ex;
        if (diff <= 0) destr = 0;
        else if (diff > 64'sd16777215) destr = 64'(DESTR_MAX);
        else destr = diff;
        refv = dref_q == 0 ? 64'd1 : 64'(dref_q);
        imp = ((destr << 16) + refv / 2) / refv;
        if (imp > 64'(IMP_ONE)) imp = 64'(IMP_ONE);
        o.energy_rate = r.electrical_power;
        o.exergy_rate = ex[39:0];
        o.exergy_destruction = destr[23:0];
        o.impact_factor = imp[16:0];
        return o;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(0, 2);
        if (r < 19) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // telemetry sample: mostly plausible plant values, some noise
    function automatic t_in_req random_sample();
        t_in_req r;
        int      sel;
        sel = $urandom_range(0, 19);
        r.flow_rate = 20'($urandom_range(0, 65536 * 2));
        r.pump_head = 16'($urandom_range(0, 256 * 80));
        r.electrical_power = 24'($urandom_range(0, 256 * 500));
        r.fluid_temperature = 17'($urandom_range(270 * 256, 400 * 256));
        r.ambient_temperature = 17'($urandom_range(270 * 256, 310 * 256));
        r.fluid_pressure = 24'($urandom_range(50000, 2000000));
        r.ambient_pressure = 24'($urandom_range(90000, 110000));
        if (sel < 3) begin
            r = t_in_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else if (sel == 3) begin
            r.fluid_temperature = '0;
        end else if (sel == 4) begin
            r.ambient_temperature = '0;
        end else if (sel == 5) begin
            r.fluid_temperature = r.ambient_temperature;
        end else if (sel == 6) begin
            r.fluid_pressure = 24'($urandom_range(0, 90000));
        end
        return r;
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        case (idx)
            CFG_DENSITY: density_q = data[10:0];
            CFG_HEAT:    heat_cap_q = data[12:0];
            CFG_DREF:    dref_q = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // hold until every result is back and the pipeline has drained
    task automatic wait_idle();
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [23:0] rho, input logic [23:0] cp,
                              input logic [23:0] dref);
        wait_idle();
        cfg_write(CFG_DENSITY, rho);
        cfg_write(CFG_HEAT, cp);
        cfg_write(CFG_DREF, dref);
    endtask

    // offer one request and hold it until accepted
    task automatic send(input t_in_req r);
        int gap;
        gap = quiet ? 0 : gap_len();
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid = 1'b0;
            i_in_req = t_in_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req = r;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
    endtask

    task automatic random_run(input int n, input bit no_gaps);
        quiet = no_gaps;
        for (int i = 0; i < n; i++) begin
            send(random_sample());
            if (i == n / 2 && !no_gaps) begin
                // let the pipeline empty out completely once
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (result_q.size() != 0) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
        quiet = 1'b0;
    endtask

    // predict every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (rows.size() != 0 && rows[0].typed && rows[0].req == i_in_req) begin
                result_q.push_back(rows[0].res);
            end else begin
                result_q.push_back(exergy_eval(i_in_req));
            end
            if (rows.size() != 0 && rows[0].req == i_in_req) void'(rows.pop_front());
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result %h", o_out_res);
            end else begin
                want = result_q.pop_front();
                if (o_out_res.energy_rate !== want.energy_rate
                        || o_out_res.exergy_rate !== want.exergy_rate
                        || o_out_res.exergy_destruction !== want.exergy_destruction
                        || o_out_res.impact_factor !== want.impact_factor) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: energy %h/%h exergy %h/%h destr %h/%h impact %h/%h",
                                 want.energy_rate, o_out_res.energy_rate,
                                 want.exergy_rate, o_out_res.exergy_rate,
                                 want.exergy_destruction, o_out_res.exergy_destruction,
                                 want.impact_factor, o_out_res.impact_factor);
                end
            end
        end
    end

    // random backpressure on the result side
    initial begin
        int hold;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_out_stall = 1'b0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                i_out_stall = $urandom_range(0, 2) == 0;
                hold = gap_len();
            end
        end
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_row    row;
        t_in_req z;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_DENSITY;
        i_cfg_data = '0;
        density_q = 11'd1000;
        heat_cap_q = 13'd4182;
        dref_q = 24'd2560;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        quiet = 1'b0;

        // directed samples: extremes, zero temperatures, pressure signs
        z = '0;
        row.typed = 1'b1;
        row.req = z;
        row.res = '0;
        rows.push_back(row);
        row.req = z;
        row.req.electrical_power = '1;
        row.res = '{energy_rate: DESTR_MAX, exergy_rate: '0,
                    exergy_destruction: DESTR_MAX, impact_factor: IMP_ONE};
        rows.push_back(row);
        row.req = z;
        row.req.electrical_power = 24'd1280;
        row.res = '{energy_rate: 24'd1280, exergy_rate: '0,
                    exergy_destruction: 24'd1280, impact_factor: 17'd32768};
        rows.push_back(row);
        row.req = z;
        row.req.electrical_power = 24'd2560;
        row.res = '{energy_rate: 24'd2560, exergy_rate: '0,
                    exergy_destruction: 24'd2560, impact_factor: IMP_ONE};
        rows.push_back(row);
        row.typed = 1'b0;
        row.res = '0;
        row.req = '1;
        rows.push_back(row);
        row.req = '1;
        row.req.ambient_pressure = '0;
        rows.push_back(row);
        row.req = '1;
        row.req.fluid_pressure = '0;
        rows.push_back(row);
        row.req = '1;
        row.req.ambient_temperature = 17'd1;
        rows.push_back(row);
        row.req = '1;
        row.req.fluid_temperature = 17'd1;
        rows.push_back(row);
        row.req = '1;
        row.req.fluid_temperature = '0;
        rows.push_back(row);
        row.req = '1;
        row.req.ambient_temperature = '0;
        rows.push_back(row);
        row.req = '{flow_rate: 20'd65536, pump_head: 16'd5120, electrical_power: 24'd2560,
                    fluid_temperature: 17'd76800, ambient_temperature: 17'd76800,
                    fluid_pressure: 24'd101325, ambient_pressure: 24'd101325};
        rows.push_back(row);
        row.req.fluid_temperature = 17'd71680;
        rows.push_back(row);
        row.req.fluid_temperature = 17'd92160;
        row.req.fluid_pressure = 24'd300000;
        rows.push_back(row);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // walk the directed table at reset configuration
        foreach (rows[i]) send(rows[i].req);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_idle();

        random_run(200, 1'b0);
        set_config(24'd900, 24'd1000, 24'd1);
        random_run(200, 1'b0);
        set_config(24'd1100, 24'd5000, 24'd16777215);
        random_run(200, 1'b1);
        set_config(24'd2047, 24'd8191, 24'd0);
        cfg_write(CFG_UNUSED, 24'hFFFFFF);
        random_run(200, 1'b0);
        set_config(24'd0, 24'd0, 24'd300);
        random_run(150, 1'b0);
        set_config(24'd1000, 24'd4182, 24'd2560);
        random_run(250, 1'b0);

        wait_idle();
        $display("Sent %0d requests over six register settings, checked %0d results.",
                 requests_sent, results_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/pee_pkg.sv
design/pump_exergy_evaluator_top.sv
tb/sv/testbench.sv
